### rtl/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, codes and byte-level functions of the AES-128 cipher unit.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int NUM_RK    = 11;
    localparam int RK_IDX_W  = 4;
    localparam logic [RK_IDX_W-1:0] LAST_RK = RK_IDX_W'(NUM_RK - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(1);

    localparam logic [63:0] KEY_HIGH_RST = 64'h0801040304090207;
    localparam logic [63:0] KEY_LOW_RST  = 64'h09090A0D010D0E0F;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_INIT,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_aes_in;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_aes_out;

    localparam logic [2047:0] SBOX_TAB = {
        128'h637C777BF26B6FC53001672BFED7AB76,
        128'hCA82C97DFA5947F0ADD4A2AF9CA472C0,
        128'hB7FD9326363FF7CC34A5E5F171D83115,
        128'h04C723C31896059A071280E2EB27B275,
        128'h09832C1A1B6E5AA0523BD6B329E32F84,
        128'h53D100ED20FCB15B6ACBBE394A4C58CF,
        128'hD0EFAAFB434D338545F9027F503C9FA8,
        128'h51A3408F929D38F5BCB6DA2110FFF3D2,
        128'hCD0C13EC5F974417C4A77E3D645D1973,
        128'h60814FDC222A908846EEB814DE5E0BDB,
        128'hE0323A0A4906245CC2D3AC629195E479,
        128'hE7C8376D8DD54EA96C56F4EA657AAE08,
        128'hBA78252E1CA6B4C6E8DD741F4BBD8B8A,
        128'h703EB5664803F60E613557B986C11D9E,
        128'hE1F8981169D98E949B1E87E9CE5528DF,
        128'h8CA1890DBFE6426841992D0FB054BB16
    };

    localparam logic [2047:0] INV_SBOX_TAB = {
        128'h52096AD53036A538BF40A39E81F3D7FB,
        128'h7CE339829B2FFF87348E4344C4DEE9CB,
        128'h547B9432A6C2233DEE4C950B42FAC34E,
        128'h082EA16628D924B2765BA2496D8BD125,
        128'h72F8F66486689816D4A45CCC5D65B692,
        128'h6C704850FDEDB9DA5E154657A78D9D84,
        128'h90D8AB008CBCD30AF7E45805B8B34506,
        128'hD02C1E8FCA3F0F02C1AFBD0301138A6B,
        128'h3A9111414F67DCEA97F2CFCEF0B4E673,
        128'h96AC7422E7AD3585E2F937E81C75DF6E,
        128'h47F11A711D29C5896FB7620EAA18BE1B,
        128'hFC563E4BC6D279209ADBC0FE78CD5AF4,
        128'h1FDDA8338807C731B11210592780EC5F,
        128'h60517FA919B54A0D2DE57A9F93C99CEF,
        128'hA0E03B4DAE2AF5B0C8EBBB3C83539961,
        128'h172B047EBA77D626E169146355210C7D
    };

    function automatic logic [7:0] sbox(input logic [7:0] a);
        sbox = SBOX_TAB[2047 - 8 * a -: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        inv_sbox = INV_SBOX_TAB[2047 - 8 * a -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [RK_IDX_W-1:0] idx);
        case (idx)
            4'd1:    rcon = 8'h01;
            4'd2:    rcon = 8'h02;
            4'd3:    rcon = 8'h04;
            4'd4:    rcon = 8'h08;
            4'd5:    rcon = 8'h10;
            4'd6:    rcon = 8'h20;
            4'd7:    rcon = 8'h40;
            4'd8:    rcon = 8'h80;
            4'd9:    rcon = 8'h1B;
            4'd10:   rcon = 8'h36;
            default: rcon = 8'h00;
        endcase
    endfunction

    // Byte b of a block, byte 0 in the top bits.
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int b);
        get_byte = s[127 - 8 * b -: 8];
    endfunction

    // Next round key from the previous one; idx is the new key's number.
    function automatic logic [127:0] next_key(input logic [127:0] k,
                                              input logic [RK_IDX_W-1:0] idx);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(idx), sbox(w3[15:8]), sbox(w3[7:0]),
              sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic last);
        logic [127:0] t, m;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        m = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (c * 4 + r) -: 8] = sbox(get_byte(s, ((c + r) & 3) * 4 + r));
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(t, c * 4);
            a1 = get_byte(t, c * 4 + 1);
            a2 = get_byte(t, c * 4 + 2);
            a3 = get_byte(t, c * 4 + 3);
            m[127 - 8 * (c * 4) -: 8]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            m[127 - 8 * (c * 4 + 1) -: 8] = xtime(a1) ^ xtime(a2) ^ a2 ^ a3 ^ a0;
            m[127 - 8 * (c * 4 + 2) -: 8] = xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1;
            m[127 - 8 * (c * 4 + 3) -: 8] = xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2;
        end
        enc_round = (last ? t : m) ^ rk;
    endfunction

    // Multiply by 9, 11, 13 and 14 in GF(2^8).
    function automatic logic [31:0] inv_mul(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        inv_mul = {x8 ^ a, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ x4 ^ x2};
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic last);
        logic [127:0] t, m;
        logic [31:0] p0, p1, p2, p3;
        t = '0;
        m = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (c * 4 + r) -: 8] =
                    inv_sbox(get_byte(s, ((c - r + 4) & 3) * 4 + r));
            end
        end
        t = t ^ rk;
        // p = {9a, 11a, 13a, 14a}
        for (int c = 0; c < 4; c++) begin
            p0 = inv_mul(get_byte(t, c * 4));
            p1 = inv_mul(get_byte(t, c * 4 + 1));
            p2 = inv_mul(get_byte(t, c * 4 + 2));
            p3 = inv_mul(get_byte(t, c * 4 + 3));
            m[127 - 8 * (c * 4) -: 8]     = p0[7:0] ^ p1[23:16] ^ p2[15:8] ^ p3[31:24];
            m[127 - 8 * (c * 4 + 1) -: 8] = p1[7:0] ^ p2[23:16] ^ p3[15:8] ^ p0[31:24];
            m[127 - 8 * (c * 4 + 2) -: 8] = p2[7:0] ^ p3[23:16] ^ p0[15:8] ^ p1[31:24];
            m[127 - 8 * (c * 4 + 3) -: 8] = p3[7:0] ^ p0[23:16] ^ p1[15:8] ^ p2[31:24];
        end
        dec_round = last ? t : m;
    endfunction

endpackage

### rtl/aes128_block_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_cipher_unit
// AES-128 encrypt/decrypt of one 16-byte block per command, one round a cycle.
// ----------------------------------------------------------------------------
//  channel   signals                              transfer when
//  command   i_start, busy, i_data                 i_start && !busy
//  result    o_done, o_result                      o_done (one cycle, no stall)
//  config    i_cfg_valid, o_cfg_ready, index/data  i_cfg_valid && o_cfg_ready
//
//  After a block's transfer, the unit does the initial key addition (ST_INIT),
//  then ten rounds of the shared round unit (ST_ROUND); o_done pulses after the
//  last round. busy drops with o_done, so the next command may transfer while
//  o_done is high.
//  Reset, and every key register write, run the key schedule, one round key a
//  cycle, with busy high and o_cfg_ready low. The receiver cannot stall; each
//  result is flagged by o_done for one cycle only.
// ----------------------------------------------------------------------------
module aes128_block_cipher_unit
    import aes_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 busy,
    input  t_aes_in              i_data,
    output logic                 o_done,
    output t_aes_out             o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    t_state r_state, n_state;

    logic [63:0]          r_key_high;
    logic [63:0]          r_key_low;
    logic [127:0]         r_rk [NUM_RK];   // round key store, one entry per round key
    logic [127:0]         r_prev_key;      // last key produced by the schedule
    logic [RK_IDX_W-1:0]  r_kidx;          // schedule position
    logic [RK_IDX_W-1:0]  r_round;         // round key used by the cipher this cycle
    logic                 r_kind;
    logic [127:0]         r_blk;
    logic                 r_done;

    logic                 start_xfer;
    logic                 cfg_xfer;
    logic                 key_write;
    logic                 last_round;
    logic [127:0]         sched_key;
    logic [127:0]         cur_rk;

    assign start_xfer = i_start && !busy;
    assign cfg_xfer   = i_cfg_valid && o_cfg_ready;
    assign key_write  = cfg_xfer &&
                        (i_cfg_index == CFG_KEY_HIGH || i_cfg_index == CFG_KEY_LOW);
    assign cur_rk     = r_rk[r_round];
    assign last_round = (r_kind == KIND_ENC) ? (r_round == LAST_RK)
                                             : (r_round == '0);
    // Position zero loads the cipher key itself; later positions derive.
    assign sched_key  = (r_kidx == '0) ? {r_key_high, r_key_low}
                                       : next_key(r_prev_key, r_kidx);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start_xfer) begin
                    n_state = ST_INIT;
                end else if (key_write) begin
                    n_state = ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (r_kidx == LAST_RK) begin
                    n_state = ST_IDLE;
                end
            end
            ST_INIT: begin
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (last_round) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb begin
        busy        = 1'b1;
        o_cfg_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy        = 1'b0;
                o_cfg_ready = !i_start;   // a command takes the cycle
            end
            default: begin
                busy        = 1'b1;
                o_cfg_ready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_EXPAND;
            r_kidx     <= '0;
            r_done     <= 1'b0;
            r_key_high <= KEY_HIGH_RST;
            r_key_low  <= KEY_LOW_RST;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_ROUND) && last_round;
            if (r_state == ST_EXPAND) begin
                r_kidx <= r_kidx + RK_IDX_W'(1);
            end else begin
                r_kidx <= '0;
            end
            if (cfg_xfer && i_cfg_index == CFG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
            end
            if (cfg_xfer && i_cfg_index == CFG_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end
        end
    end

    // Key schedule and cipher datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXPAND) begin
            r_rk[r_kidx] <= sched_key;
            r_prev_key   <= sched_key;
        end
        case (r_state)
            ST_IDLE: begin
                if (start_xfer) begin
                    r_kind  <= i_data.kind;
                    r_blk   <= {i_data.block_high, i_data.block_low};
                    r_round <= (i_data.kind == KIND_ENC) ? '0 : LAST_RK;
                end
            end
            ST_INIT: begin
                r_blk   <= r_blk ^ cur_rk;
                r_round <= (r_kind == KIND_ENC) ? r_round + RK_IDX_W'(1)
                                                : r_round - RK_IDX_W'(1);
            end
            ST_ROUND: begin
                if (r_kind == KIND_ENC) begin
                    r_blk   <= enc_round(r_blk, cur_rk, last_round);
                    r_round <= r_round + RK_IDX_W'(1);
                end else begin
                    r_blk   <= dec_round(r_blk, cur_rk, last_round);
                    r_round <= r_round - RK_IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = {r_blk[127:64], r_blk[63:0]};

    // A result only ever follows a final round.
    a_done_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == ST_ROUND)
        else $error("result strobe without a final round");

    // A command transfer starts the initial key addition.
    a_start_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_xfer |=> r_state == ST_INIT)
        else $error("command transfer did not start the cipher");

    // A key write reruns the schedule from its first key.
    a_key_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_write |=> (r_state == ST_EXPAND && r_kidx == '0))
        else $error("key write did not restart the schedule");

    // The strobe and busy never overlap.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

endmodule

### sim/aes128_block_cipher_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_cipher_unit_test
// Self-checking bench for the AES-128 cipher unit. A software cipher predicts
// every block at its command transfer; the monitor compares each o_done pulse
// with the oldest prediction. Phases vary the key (reset, the standard test
// key, zeros, ones, random) and the command idling.
// ----------------------------------------------------------------------------
module aes128_block_cipher_unit_test;
    import aes_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 240;
    localparam int NUM_PHASES     = 5;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 busy;
    t_aes_in              i_data;
    logic                 o_done;
    t_aes_out             o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;

    aes128_block_cipher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .busy        (busy),
        .i_data      (i_data),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state: substitution tables, key registers, expanded keys.
    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [63:0]  key_hi_q;
    logic [63:0]  key_lo_q;
    logic [127:0] sched [11];

    t_aes_in  block_queue [$];
    t_aes_out cipher_queue [$];

    int mismatches;
    int blocks_sent;
    int blocks_seen;
    int idle_pct;
    int stall_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (a[i]) r ^= b;
            b = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
        end
        return r;
    endfunction

    // Derive both substitution tables from the field inverse and affine map.
    task automatic build_tables();
        logic [7:0] inv, s;
        for (int a = 0; a < 256; a++) begin
            inv = '0;
            for (int b = 1; b < 256; b++) begin
                if (gf_mul(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[a] = s;
            inv_sub[s] = 8'(a);
        end
    endtask

    task automatic expand_schedule();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        w[0] = key_hi_q[63:32];
        w[1] = key_hi_q[31:0];
        w[2] = key_lo_q[63:32];
        w[3] = key_lo_q[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]],
                     fwd_sub[t[31:24]]};
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1B : 8'h00);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int k = 0; k < 11; k++) sched[k] = {w[4*k], w[4*k+1], w[4*k+2], w[4*k+3]};
    endtask

    // Byte c*4+r is row r of column c, byte 0 in the top bits.
    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic dec);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = dec ? (((c - r + 4) & 3) * 4 + r) : (((c + r) & 3) * 4 + r);
                t[127 - 8*(c*4+r) -: 8] = dec ? inv_sub[s[127 - 8*src -: 8]]
                                              : fwd_sub[s[127 - 8*src -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic dec);
        logic [7:0]   m [4];
        logic [7:0]   col [4];
        logic [127:0] t;
        if (dec) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) col[r] = s[127 - 8*(c*4+r) -: 8];
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(c*4+r) -: 8] = gf_mul(m[0], col[r]) ^ gf_mul(m[1], col[(r+1)&3])
                    ^ gf_mul(m[2], col[(r+2)&3]) ^ gf_mul(m[3], col[(r+3)&3]);
            end
        end
        return t;
    endfunction

    function automatic t_aes_out cipher_block(input t_aes_in item);
        logic [127:0] s;
        t_aes_out     res;
        s = {item.block_high, item.block_low};
        if (item.kind == KIND_ENC) begin
            s ^= sched[0];
            for (int rnd = 1; rnd <= 10; rnd++) begin
                s = sub_shift(s, 1'b0);
                if (rnd != 10) s = mix(s, 1'b0);
                s ^= sched[rnd];
            end
        end else begin
            s ^= sched[10];
            for (int rnd = 9; rnd >= 0; rnd--) begin
                s = sub_shift(s, 1'b1) ^ sched[rnd];
                if (rnd != 0) s = mix(s, 1'b1);
            end
        end
        res.result_high = s[127:64];
        res.result_low  = s[63:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: %s want %h got %h", $realtime, what, want, got);
        mismatches++;
    endtask

    // Write one register; update the predictor only for the two key indexes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_KEY_HIGH) key_hi_q = val;
        if (idx == CFG_KEY_LOW)  key_lo_q = val;
        if (idx == CFG_KEY_HIGH || idx == CFG_KEY_LOW) expand_schedule();
    endtask

    function automatic t_aes_in make_block(input logic kind, input logic [63:0] hi,
                                           input logic [63:0] lo);
        t_aes_in b;
        b.kind = kind;
        b.block_high = hi;
        b.block_low = lo;
        return b;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Driver: record a prediction on every command transfer, then offer the
    // next block unless this cycle is chosen to idle. Hold while busy.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !busy) begin
                cipher_queue.push_back(cipher_block(i_data));
                blocks_sent++;
            end
            if (!i_start || !busy) begin
                if (block_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_data  <= block_queue.pop_front();
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every o_done pulse is one result transfer.
    always @(posedge i_clk) begin
        t_aes_out want;
        if (i_rst_n && o_done) begin
            blocks_seen++;
            if (cipher_queue.size() == 0) begin
                report_mismatch("result with nothing pending", '0, o_result.result_high);
            end else begin
                want = cipher_queue.pop_front();
                if (o_result.result_high !== want.result_high)
                    report_mismatch("result_high", want.result_high, o_result.result_high);
                if (o_result.result_low !== want.result_low)
                    report_mismatch("result_low", want.result_low, o_result.result_low);
            end
        end
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic drain();
        wait (block_queue.size() == 0);
        @(posedge i_clk);
        while (i_start || cipher_queue.size() != 0) @(posedge i_clk);
        repeat (15) @(posedge i_clk);
    endtask

    initial begin
        int modes [NUM_PHASES];
        modes = '{0, 49, 0, 25, 49};
        mismatches  = 0;
        blocks_sent = 0;
        blocks_seen = 0;
        stall_count = 0;
        idle_pct    = 0;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_data      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        build_tables();
        key_hi_q = KEY_HIGH_RST;
        key_lo_q = KEY_LOW_RST;
        expand_schedule();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: begin
                    write_reg(CFG_KEY_HIGH, 64'h0001020304050607);
                    write_reg(CFG_KEY_LOW,  64'h08090A0B0C0D0E0F);
                end
                2: begin
                    write_reg(CFG_KEY_HIGH, '0);
                    write_reg(CFG_KEY_LOW,  '0);
                    // indexes past the key registers must leave the key alone
                    write_reg(CFG_IDX_W'(2), rand64());
                    write_reg('1, rand64());
                end
                3: begin
                    write_reg(CFG_KEY_HIGH, '1);
                    write_reg(CFG_KEY_LOW,  '1);
                end
                4: begin
                    write_reg(CFG_KEY_LOW,  rand64());
                    write_reg(CFG_KEY_HIGH, rand64());
                end
                default: ;
            endcase
            @(negedge i_clk);
            idle_pct = modes[ph];
            // Directed blocks: extremes, the standard plaintext and its ciphertext, top and bottom bits, both kinds.
            for (int k = 0; k < 2; k++) begin
                block_queue.push_back(make_block(k[0], '0, '0));
                block_queue.push_back(make_block(k[0], '1, '1));
                block_queue.push_back(make_block(k[0], 64'h0011223344556677,
                                                 64'h8899AABBCCDDEEFF));
                block_queue.push_back(make_block(k[0], 64'h69C4E0D86A7B0430,
                                                 64'hD8CDB78070B4C55A));
                block_queue.push_back(make_block(k[0], 64'h8000000000000000, 64'h1));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                block_queue.push_back(make_block(1'($urandom_range(1)), rand64(),
                                                 rand64()));
            drain();
        end

        $display("Covered %0d blocks sent, %0d results checked, five keys, idling 0-49%%.",
                 blocks_sent, blocks_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/aes_pkg.sv
rtl/aes128_block_cipher_unit.sv
sim/aes128_block_cipher_unit_test.sv
